>>> rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants shared by the ray/wall segment intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CoordWidth = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int MagWidth   = CrossWidth - 1;
  localparam int QuotWidth  = DiffWidth;
  localparam int NumWallRegs = 4;
  localparam int IdxWidth    = 2;

  typedef enum logic [IdxWidth-1:0] {
    REG_WALL_START_X = 2'd0,
    REG_WALL_START_Y = 2'd1,
    REG_WALL_END_X   = 2'd2,
    REG_WALL_END_Y   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] ray_start_x;
    logic signed [CoordWidth-1:0] ray_start_y;
    logic signed [CoordWidth-1:0] ray_end_x;
    logic signed [CoordWidth-1:0] ray_end_y;
  } ray_req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] hit_x;
    logic signed [CoordWidth-1:0] hit_y;
  } ray_res_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] wall_start_x;
    logic signed [CoordWidth-1:0] wall_start_y;
    logic signed [CoordWidth-1:0] wall_end_x;
    logic signed [CoordWidth-1:0] wall_end_y;
  } wall_t;

  // Per-item payload leaving the cross-product front end.
  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] py;
    logic                         rx_neg;
    logic                         ry_neg;
    logic [DiffWidth-1:0]         rx_mag;
    logic [DiffWidth-1:0]         ry_mag;
    logic [MagWidth-1:0]          tn;
    logic [MagWidth-1:0]          den;
  } rsi_geo_t;

endpackage

>>> rtl/rsi_cross.sv
// ----------------------------------------------------------------------------
// rsi_cross
// Front end: differences, three cross products, sign fold and hit test.
// Three register stages.
// ----------------------------------------------------------------------------
module rsi_cross import rsi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  ray_req_t req,
  input  wall_t    wall,
  output logic     out_valid,
  output rsi_geo_t geo
);

  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] crs_t;

  logic  v1, v2, v3;
  diff_t rx1, ry1, sx1, sy1, qx1, qy1;
  logic signed [CoordWidth-1:0] px1, py1, px2, py2;
  prod_t p_rs_a, p_rs_b, p_qs_a, p_qs_b, p_qr_a, p_qr_b;
  diff_t rx2, ry2;
  crs_t  den_s, tn_s, un_s;
  crs_t  den_f, tn_f, un_f;
  logic  hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    px1 <= req.ray_start_x;
    py1 <= req.ray_start_y;
    rx1 <= diff_t'(req.ray_end_x) - diff_t'(req.ray_start_x);
    ry1 <= diff_t'(req.ray_end_y) - diff_t'(req.ray_start_y);
    sx1 <= diff_t'(wall.wall_end_x) - diff_t'(wall.wall_start_x);
    sy1 <= diff_t'(wall.wall_end_y) - diff_t'(wall.wall_start_y);
    qx1 <= diff_t'(wall.wall_start_x) - diff_t'(req.ray_start_x);
    qy1 <= diff_t'(wall.wall_start_y) - diff_t'(req.ray_start_y);
  end

  always_ff @(posedge clk) begin
    px2    <= px1;
    py2    <= py1;
    rx2    <= rx1;
    ry2    <= ry1;
    p_rs_a <= prod_t'(rx1) * prod_t'(sy1);
    p_rs_b <= prod_t'(ry1) * prod_t'(sx1);
    p_qs_a <= prod_t'(qx1) * prod_t'(sy1);
    p_qs_b <= prod_t'(qy1) * prod_t'(sx1);
    p_qr_a <= prod_t'(qx1) * prod_t'(ry1);
    p_qr_b <= prod_t'(qy1) * prod_t'(rx1);
  end

  always_comb begin
    den_s = crs_t'(p_rs_a) - crs_t'(p_rs_b);
    tn_s  = crs_t'(p_qs_a) - crs_t'(p_qs_b);
    un_s  = crs_t'(p_qr_a) - crs_t'(p_qr_b);
    if (den_s[CrossWidth-1]) begin
      den_f = -den_s;
      tn_f  = -tn_s;
      un_f  = -un_s;
    end else begin
      den_f = den_s;
      tn_f  = tn_s;
      un_f  = un_s;
    end
    hit_c = (den_f != '0) && !tn_f[CrossWidth-1] && (tn_f <= den_f)
            && !un_f[CrossWidth-1] && (un_f <= den_f);
  end

  always_ff @(posedge clk) begin
    geo.hit    <= hit_c;
    geo.px     <= px2;
    geo.py     <= py2;
    geo.rx_neg <= rx2[DiffWidth-1];
    geo.ry_neg <= ry2[DiffWidth-1];
    geo.rx_mag <= rx2[DiffWidth-1] ? DiffWidth'(-rx2) : DiffWidth'(rx2);
    geo.ry_mag <= ry2[DiffWidth-1] ? DiffWidth'(-ry2) : DiffWidth'(ry2);
    geo.tn     <= tn_f[MagWidth-1:0];
    geo.den    <= den_f[MagWidth-1:0];
  end

  assign out_valid = v3;

endmodule

>>> rtl/rsi_divide.sv
// ----------------------------------------------------------------------------
// rsi_divide
// Back end: scale r by tn in registered partial products, then a pipelined
// restoring division, one quotient bit per stage, for both axes in lanes.
// ----------------------------------------------------------------------------
module rsi_divide import rsi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  rsi_geo_t geo,
  output logic     out_valid,
  output ray_res_t res
);

  localparam int HalfW  = (MagWidth + 1) / 2;
  localparam int NumW   = DiffWidth + MagWidth;
  localparam int Stages = QuotWidth;
  localparam int RemW   = MagWidth + 1;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] py;
    logic                         rx_neg;
    logic                         ry_neg;
    logic [MagWidth-1:0]          den;
  } meta_t;

  logic  v0;
  meta_t m0;
  logic [DiffWidth+HalfW-1:0] xl, xh, yl, yh;
  logic [NumW-1:0] nx_c, ny_c;

  logic  sv [Stages+1];
  meta_t sm [Stages+1];
  logic [NumW-1:0] nx [Stages+1];
  logic [NumW-1:0] ny [Stages+1];
  logic [RemW-1:0] rmx [Stages+1];
  logic [RemW-1:0] rmy [Stages+1];
  logic [QuotWidth-1:0] qx [Stages+1];
  logic [QuotWidth-1:0] qy [Stages+1];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    m0 <= '{hit: geo.hit, px: geo.px, py: geo.py, rx_neg: geo.rx_neg,
            ry_neg: geo.ry_neg, den: geo.den};
    xl <= (DiffWidth+HalfW)'(geo.rx_mag) * (DiffWidth+HalfW)'(geo.tn[HalfW-1:0]);
    xh <= (DiffWidth+HalfW)'(geo.rx_mag) *
          (DiffWidth+HalfW)'(geo.tn[MagWidth-1:HalfW]);
    yl <= (DiffWidth+HalfW)'(geo.ry_mag) * (DiffWidth+HalfW)'(geo.tn[HalfW-1:0]);
    yh <= (DiffWidth+HalfW)'(geo.ry_mag) *
          (DiffWidth+HalfW)'(geo.tn[MagWidth-1:HalfW]);
  end

  assign nx_c = NumW'(xl) + (NumW'(xh) << HalfW);
  assign ny_c = NumW'(yl) + (NumW'(yh) << HalfW);

  // Quotient fits DiffWidth bits since tn <= den; top bits of the numerator
  // above the quotient span go straight into the remainder.
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else     sv[0] <= v0;
  end

  always_ff @(posedge clk) begin
    sm[0]  <= m0;
    nx[0]  <= nx_c;
    ny[0]  <= ny_c;
    rmx[0] <= RemW'(nx_c[NumW-1:QuotWidth]);
    rmy[0] <= RemW'(ny_c[NumW-1:QuotWidth]);
    qx[0]  <= '0;
    qy[0]  <= '0;
  end

  for (genvar g = 0; g < Stages; g++) begin : g_div
    logic [RemW-1:0] tx, ty;
    logic            gx, gy;
    always_comb begin
      tx = {rmx[g][RemW-2:0], nx[g][QuotWidth-1-g]};
      ty = {rmy[g][RemW-2:0], ny[g][QuotWidth-1-g]};
      gx = tx >= RemW'(sm[g].den);
      gy = ty >= RemW'(sm[g].den);
    end
    always_ff @(posedge clk) begin
      if (rst) sv[g+1] <= 1'b0;
      else     sv[g+1] <= sv[g];
    end
    always_ff @(posedge clk) begin
      sm[g+1]  <= sm[g];
      nx[g+1]  <= nx[g];
      ny[g+1]  <= ny[g];
      rmx[g+1] <= gx ? tx - RemW'(sm[g].den) : tx;
      rmy[g+1] <= gy ? ty - RemW'(sm[g].den) : ty;
      qx[g+1]  <= {qx[g][QuotWidth-2:0], gx};
      qy[g+1]  <= {qy[g][QuotWidth-2:0], gy};
    end
  end

  logic signed [DiffWidth:0] hx, hy;
  meta_t mf;
  assign mf = sm[Stages];

  always_comb begin
    hx = (DiffWidth+1)'(mf.px) + (mf.rx_neg ? -(DiffWidth+1)'(qx[Stages])
                                             : (DiffWidth+1)'(qx[Stages]));
    hy = (DiffWidth+1)'(mf.py) + (mf.ry_neg ? -(DiffWidth+1)'(qy[Stages])
                                             : (DiffWidth+1)'(qy[Stages]));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= sv[Stages];
  end

  always_ff @(posedge clk) begin
    res.hit   <= mf.hit;
    res.hit_x <= mf.hit ? hx[CoordWidth-1:0] : '0;
    res.hit_y <= mf.hit ? hy[CoordWidth-1:0] : '0;
  end

endmodule

>>> rtl/ray_segment_intersection.sv
// ----------------------------------------------------------------------------
// ray_segment_intersection
// Tests one ray segment per cycle against a wall segment held in registers.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+--------------------------
//  request  | start, busy, req              | taken when start & !busy
//  result   | done, res                     | one cycle, no back-pressure
//  config   | cfg_we, cfg_idx, cfg_data     | written when cfg_we
//
// One request per cycle; the divider resolves one quotient bit per stage.
// busy is always low. Reset clears valid bits and the wall registers.
// ----------------------------------------------------------------------------
module ray_segment_intersection import rsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ray_req_t              req,
  output logic                  done,
  output ray_res_t              res,
  input  logic                  cfg_we,
  input  logic [IdxWidth-1:0]   cfg_idx,
  input  logic [CoordWidth-1:0] cfg_data
);

  wall_t    wall;
  logic     geo_valid;
  rsi_geo_t geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_WALL_START_X: wall.wall_start_x <= cfg_data;
        REG_WALL_START_Y: wall.wall_start_y <= cfg_data;
        REG_WALL_END_X:   wall.wall_end_x   <= cfg_data;
        REG_WALL_END_Y:   wall.wall_end_y   <= cfg_data;
        default:          wall <= wall;
      endcase
    end
  end

  assign busy = 1'b0;

  rsi_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .req       (req),
    .wall      (wall),
    .out_valid (geo_valid),
    .geo       (geo)
  );

  rsi_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (geo_valid),
    .geo       (geo),
    .out_valid (done),
    .res       (res)
  );

endmodule

>>> rtl/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the intersection pipeline.
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input ray_res_t res
);

  localparam int Latency = 23;

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    done && !res.hit |-> res.hit_x == '0 && res.hit_y == '0)
    else $error("miss with nonzero point");

  a_done_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result straight after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_request_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##Latency done)
    else $error("request without result");

endmodule

bind ray_segment_intersection rsi_checker u_rsi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
